// ----- src/ths_pkg.sv -----
// shared constants and types for the terrain hillshade stencil
// no dependencies
package ths_pkg;

	localparam int unsigned TwiceRtHalf = 92682;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_GRAD = 5'b00100,
		ST_SQRT = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		REG_SIDE  = 2'd0,
		REG_XGAIN = 2'd1,
		REG_YGAIN = 2'd2
	} reg_idx_t;

endpackage

// ----- src/terrain_hillshade_stencil_top.sv -----
// Terrain hillshade stencil: line buffers, window, gradients, sqrt and divide
// depends on ths_pkg
//
// One elevation per transfer on the s_axis side (signed Q23.8, raster order).
// Results leave on m_axis: tdata holds shade, out_col, out_row from bit 0 up;
// tuser holds run_last (bit 0) and tile_done (bit 1).
// Configuration: cfg_we with cfg_index 0 tile_side, 1 x_gain, 2 y_gain; the user
// writes it only while idle, as the block itself does not enforce this.
// Each item is taken one at a time. An item that yields no result passes
// through accept, then line buffer update. An interior item also runs the
// gradient phases, a 33-step square root and a 9-step restoring divide;
// then 1 to 4 results go out one per cycle while m_axis_tready is high.
// A stalled receiver holds the output register and the block waits.
// Reset clears counters and control; line buffers are not cleared and hold
// nothing meaningful until a tile has passed through them.
// Outputs come in order of interior item, each with its border copies, row by row.
module terrain_hillshade_stencil_top #(
	parameter int MAX_SIDE   = 256,
	parameter int ELEV_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [ELEV_WIDTH-1:0] s_axis_tdata,  // elevation
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [23:0]           m_axis_tdata,  // shade, out_col, out_row
	output logic [1:0]            m_axis_tuser   // run_last, tile_done
);
	localparam int AW = $clog2(MAX_SIDE);
	localparam int CW = $clog2(MAX_SIDE + 1);

	ths_pkg::state_t state_q;
	logic [8:0]  side_reg_q;
	logic [31:0] xgain_q, ygain_q;
	logic [CW-1:0] col_q, row_q, c_q, r_q, side_q;
	logic signed [ELEV_WIDTH-1:0] e_q;
	logic signed [ELEV_WIDTH-1:0] lp_mem [MAX_SIDE];
	logic signed [ELEV_WIDTH-1:0] lp2_mem [MAX_SIDE];
	logic signed [ELEV_WIDTH-1:0] up_s1, up2_s1;
	logic signed [ELEV_WIDTH-1:0] w0_q, w2_q, w3_q, w4_q;

	// clamped side
	logic [CW-1:0] side_c;
	always_comb begin
		if (side_reg_q < 9'd4) side_c = CW'(4);
		else if (32'(side_reg_q) > 32'(MAX_SIDE))
			side_c = CW'(MAX_SIDE);
		else side_c = CW'(side_reg_q);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_reg_q <= 9'd256;
			xgain_q    <= 32'd8388608;
			ygain_q    <= 32'd8388608;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ths_pkg::REG_SIDE:  side_reg_q <= cfg_data[8:0];
				ths_pkg::REG_XGAIN: xgain_q    <= cfg_data;
				ths_pkg::REG_YGAIN: ygain_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// position of incoming item
	logic [CW-1:0] c_n, r_n;
	always_comb begin
		c_n = col_q;
		r_n = row_q;
		if (c_n >= side_c) begin
			c_n = '0;
			r_n = r_n + 1'b1;
		end
		if (r_n >= side_c) r_n = '0;
	end

	assign s_axis_tready = (state_q == ths_pkg::ST_IDLE);
	wire in_xfer = s_axis_tvalid && s_axis_tready;

	// line buffers: registered read at accept, written back in ST_READ
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			up_s1  <= lp_mem[c_n[AW-1:0]];
			up2_s1 <= lp2_mem[c_n[AW-1:0]];
		end
		if (state_q == ths_pkg::ST_READ) begin
			lp2_mem[c_q[AW-1:0]] <= up_s1;
			lp_mem[c_q[AW-1:0]]  <= e_q;
		end
	end

	// gradient operands
	logic signed [ELEV_WIDTH:0] dx, dy;
	logic [ELEV_WIDTH:0] mx, my;
	logic [ELEV_WIDTH:0] mx_q, my_q;
	logic [ELEV_WIDTH+32:0] px, py;
	logic [31:0] gxm_q, gym_q;
	logic gxn_q, gyn_q;
	assign dx = {up_s1[ELEV_WIDTH-1], up_s1} - {w3_q[ELEV_WIDTH-1], w3_q};
	assign dy = {w4_q[ELEV_WIDTH-1], w4_q} - {w0_q[ELEV_WIDTH-1], w0_q};
	assign mx = dx[ELEV_WIDTH] ? (ELEV_WIDTH+1)'(0) - dx : dx;
	assign my = dy[ELEV_WIDTH] ? (ELEV_WIDTH+1)'(0) - dy : dy;

	// multiplies in ST_GRAD
	logic [ELEV_WIDTH+32:0] mulq_x, mulq_y;
	always_ff @(posedge clk) begin
		mulq_x <= (ELEV_WIDTH+33)'(mx_q) * (ELEV_WIDTH+33)'(xgain_q);
		mulq_y <= (ELEV_WIDTH+33)'(my_q) * (ELEV_WIDTH+33)'(ygain_q);
	end
	assign px = mulq_x >> 16;
	assign py = mulq_y >> 16;

	// shade datapath registers
	logic signed [33:0] num2_q;
	logic [65:0] rad_q, res_q, bit_q;
	logic [5:0] step_q;
	logic [1:0] phase_q;
	logic [42:0] rem_q;
	logic [8:0] quo_q;
	logic [33:0] den_q;
	logic [7:0] sh_q;

	// output list
	logic [7:0] rows_q [2];
	logic [7:0] cols_q [2];
	logic nr_q, nc_q, i_q, j_q, done_q;

	logic [31:0] gxs, gys;
	assign gxs = (|px[ELEV_WIDTH+32:31]) ? 32'h7fffffff : px[31:0];
	assign gys = (|py[ELEV_WIDTH+32:31]) ? 32'h7fffffff : py[31:0];

	logic [CW-1:0] ir, ic;
	assign ir = r_q - 1'b1;
	assign ic = c_q - 1'b1;

	logic [65:0] sum_rb;
	assign sum_rb = res_q + bit_q;
	logic [43:0] rem_try;
	assign rem_try = {rem_q, quo_q[8]} - {10'd0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ths_pkg::ST_IDLE;
			col_q         <= '0;
			row_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				ths_pkg::ST_IDLE: if (in_xfer) begin
					state_q <= ths_pkg::ST_READ;
					c_q <= c_n;
					r_q <= r_n;
					side_q <= side_c;
					e_q <= s_axis_tdata;
				end
				ths_pkg::ST_READ: begin
					// gradient operands from the window before it shifts
					mx_q  <= mx;
					my_q  <= my;
					gxn_q <= dx[ELEV_WIDTH];
					gyn_q <= dy[ELEV_WIDTH];
					// window updates in place
					w0_q <= up2_s1;
					w3_q <= w2_q;
					w2_q <= up_s1;
					w4_q <= e_q;
					if (c_q + 1'b1 >= side_q) begin
						col_q <= '0;
						row_q <= (r_q + 1'b1 >= side_q) ? '0 : r_q + 1'b1;
					end else begin
						col_q <= c_q + 1'b1;
						row_q <= r_q;
					end
					if (r_q >= 2 && c_q >= 2) begin
						state_q <= ths_pkg::ST_GRAD;
						phase_q <= 2'd0;
					end else state_q <= ths_pkg::ST_IDLE;
					// output coordinates
					rows_q[0] <= (ir == 1) ? 8'd0 : 8'(ir);
					rows_q[1] <= (ir == 1) ? 8'(ir) : 8'(side_q - 1'b1);
					nr_q <= (ir == 1) || (ir == side_q - 2'd2);
					cols_q[0] <= (ic == 1) ? 8'd0 : 8'(ic);
					cols_q[1] <= (ic == 1) ? 8'(ic) : 8'(side_q - 1'b1);
					nc_q <= (ic == 1) || (ic == side_q - 2'd2);
					done_q <= (ir == side_q - 2'd2) && (ic == side_q - 2'd2);
					i_q <= 1'b0;
					j_q <= 1'b0;
				end
				ths_pkg::ST_GRAD: begin
					// phase 0: products of the captured differences
					phase_q <= phase_q + 1'b1;
					if (phase_q == 2'd1) begin
						gxm_q <= gxs;
						gym_q <= gys;
					end else if (phase_q == 2'd2) begin
						num2_q <= $signed(34'(ths_pkg::TwiceRtHalf))
							- (gxn_q ? -$signed({2'b0, gxm_q}) : $signed({2'b0, gxm_q}))
							- (gyn_q ? -$signed({2'b0, gym_q}) : $signed({2'b0, gym_q}));
						rad_q <= 66'(gxm_q) * 66'(gxm_q);
						res_q <= 66'(gym_q) * 66'(gym_q);
					end else if (phase_q == 2'd3) begin
						rad_q <= rad_q + res_q + (66'd1 << 32);
						res_q <= '0;
						bit_q <= 66'd1 << 64;
						step_q <= '0;
						state_q <= ths_pkg::ST_SQRT;
					end
				end
				ths_pkg::ST_SQRT: begin
					// one sqrt digit per cycle, then a bit-serial divide
					if (step_q < 6'd33) begin
						if (rad_q >= sum_rb) begin
							rad_q <= rad_q - sum_rb;
							res_q <= (res_q >> 1) + bit_q;
						end else res_q <= res_q >> 1;
						bit_q <= bit_q >> 2;
						step_q <= step_q + 1'b1;
						if (step_q == 6'd32) begin
							rem_q <= '0;
							quo_q <= '0;
						end
					end else if (step_q == 6'd33) begin
						den_q <= {res_q[32:0], 1'b0};
						// 255*num2: top bits as partial remainder, low 9 bits shift in
						rem_q <= 43'(255 * 42'(num2_q[32:0])) >> 9;
						quo_q <= 9'(255 * 42'(num2_q[32:0]));
						step_q <= step_q + 1'b1;
					end else if (step_q < 6'd43) begin
						// next dividend bit enters from quo_q, quotient bit enters at bit 0
						if (!rem_try[43]) begin
							rem_q <= rem_try[42:0];
							quo_q <= {quo_q[7:0], 1'b1};
						end else begin
							rem_q <= {rem_q[41:0], quo_q[8]};
							quo_q <= {quo_q[7:0], 1'b0};
						end
						step_q <= step_q + 1'b1;
					end else begin
						if (num2_q <= 0) sh_q <= 8'd0;
						else sh_q <= quo_q[8] ? 8'hff : quo_q[7:0];
						state_q <= ths_pkg::ST_EMIT;
						m_axis_tvalid <= 1'b1;
					end
				end
				ths_pkg::ST_EMIT: if (m_axis_tready) begin
					if (j_q != nc_q) j_q <= 1'b1;
					else if (i_q != nr_q) begin
						j_q <= 1'b0;
						i_q <= 1'b1;
					end else begin
						m_axis_tvalid <= 1'b0;
						state_q <= ths_pkg::ST_IDLE;
					end
				end
				default: state_q <= ths_pkg::ST_IDLE;
			endcase
		end
	end

	logic last_w;
	assign last_w = (i_q == nr_q) && (j_q == nc_q);
	assign m_axis_tdata = {rows_q[i_q], cols_q[j_q], sh_q};
	assign m_axis_tuser = {last_w && done_q, last_w};

endmodule

// ----- src/ths_checker.sv -----
// port-level checks for the hillshade stencil
// binds to terrain_hillshade_stencil_top
module ths_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	// no new input while results are pending
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");
	// tile_done only with run_last
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0]) else $error("done without last");
	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output changed under stall");
endmodule

bind terrain_hillshade_stencil_top ths_checker u_ths_checker (.*);
